### design/lowest_common_ancestor_table_macros.svh
// Assertion helpers shared by the design files.
// Each macro checks on the rising edge of clk and is off while rst_n is low.
`ifndef LOWEST_COMMON_ANCESTOR_TABLE_MACROS_SVH
`define LOWEST_COMMON_ANCESTOR_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCA_TBL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCA_TBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lca_tbl_pkg.sv
package lca_tbl_pkg;

  // Fixed widths of the word fields.
  localparam int MODE_W = 2;
  localparam int NODE_W = 9;

  // Default size of the node table.
  localparam int MAX_NODES_DEF = 256;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_SET_PARENT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEPTHS     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY      = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_QRY,
    ST_CLIMB
  } state_t;

endpackage

### design/lca_tbl_if.sv
// Input channel: one command word per handshake.
interface lca_tbl_in_if;
  logic                               valid;
  logic                               ready;
  logic [lca_tbl_pkg::MODE_W-1:0]     mode;
  logic [lca_tbl_pkg::NODE_W-1:0]     node_a;
  logic [lca_tbl_pkg::NODE_W-1:0]     node_b;

  modport source (output valid, output mode, output node_a, output node_b, input ready);
  modport sink   (input valid, input mode, input node_a, input node_b, output ready);
endinterface

// Result channel: one query answer per handshake.
interface lca_tbl_out_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic [lca_tbl_pkg::NODE_W-1:0]     ancestor;

  modport source (output valid, output found, output ancestor, input ready);
  modport sink   (input valid, input found, input ancestor, output ready);
endinterface

### design/lowest_common_ancestor_table.sv
// Set parent: written at the handshake. Query: ST_QRY compares the depths, each climb step
//   reads the parent table in ST_CLIMB, and the answer waits until the output register is free.
// Depth pass: each node 1..highest id walks its chain through the parent table read port,
//   one read per node on the chain, with the depth capped at MAX_NODES.
// Throughput: one word at a time; a finished answer waits in the output register.
// Reset: synchronous, active low; a clearing pass then zeroes entries 0..MAX_NODES of
//   both tables while in_chan.ready stays low.
`include "lowest_common_ancestor_table_macros.svh"

module lowest_common_ancestor_table #(
  parameter int MAX_NODES = lca_tbl_pkg::MAX_NODES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lca_tbl_in_if.sink           in_chan,
  lca_tbl_out_if.source        out_chan
);

  localparam int NODE_W = lca_tbl_pkg::NODE_W;
  localparam int ID_W   = $clog2(MAX_NODES + 1);
  localparam int DEP_W  = $clog2(MAX_NODES + 1);
  localparam int STEP_W = $clog2(2 * MAX_NODES + 1);
  localparam int WIDE_W = (ID_W > NODE_W) ? ID_W : NODE_W;

  // Parent table and depth table.
  logic [ID_W-1:0]  par_mem [0:MAX_NODES];
  logic [DEP_W-1:0] dep_mem [0:MAX_NODES];

  lca_tbl_pkg::state_t state_r, state_nxt;

  logic [ID_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [ID_W-1:0]   highest_r, highest_nxt;
  logic [ID_W-1:0]   node_i_r, node_i_nxt;
  logic [ID_W-1:0]   walk_p_r, walk_p_nxt;
  logic [DEP_W-1:0]  cnt_r, cnt_nxt;
  logic [ID_W-1:0]   p_r, p_nxt;
  logic [ID_W-1:0]   q_r, q_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic              climb_p_r, climb_p_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [NODE_W-1:0] out_ancestor_r, out_ancestor_nxt;

  // Memory ports.
  logic              par_we;
  logic [ID_W-1:0]   par_waddr;
  logic [ID_W-1:0]   par_wdata;
  logic [ID_W-1:0]   par_raddr;
  logic [ID_W-1:0]   par_rdata_r;
  logic              dep_we;
  logic [ID_W-1:0]   dep_waddr;
  logic [DEP_W-1:0]  dep_wdata;
  logic [ID_W-1:0]   dep_raddr_p;
  logic [ID_W-1:0]   dep_raddr_q;
  logic [DEP_W-1:0]  dep_rdata_p_r;
  logic [DEP_W-1:0]  dep_rdata_q_r;

  // Range checks on the incoming node ids.
  logic [WIDE_W-1:0] a_wide;
  logic [WIDE_W-1:0] b_wide;
  logic              a_ok;
  logic              b_ok;
  logic [ID_W-1:0]   a_id;
  logic [ID_W-1:0]   b_id;
  logic              in_fire;
  logic              out_free;
  logic              walk_more;

  assign a_wide   = WIDE_W'(in_chan.node_a);
  assign b_wide   = WIDE_W'(in_chan.node_b);
  assign a_ok     = (a_wide <= WIDE_W'(MAX_NODES));
  assign b_ok     = (b_wide <= WIDE_W'(MAX_NODES));
  assign a_id     = ID_W'(a_wide);
  assign b_id     = ID_W'(b_wide);
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign walk_more = (par_rdata_r != '0) && (cnt_r < DEP_W'(MAX_NODES));

  // Words are taken only in the idle state, so no table access can overlap another.
  assign in_chan.ready     = (state_r == lca_tbl_pkg::ST_IDLE);
  assign out_chan.valid    = out_valid_r;
  assign out_chan.found    = out_found_r;
  assign out_chan.ancestor = out_ancestor_r;

  // Parent table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_rdata_r <= par_mem[par_raddr];
  end

  // Depth table: one write port, two registered read ports for the query pair.
  always_ff @(posedge clk) begin
    if (dep_we) begin
      dep_mem[dep_waddr] <= dep_wdata;
    end
    dep_rdata_p_r <= dep_mem[dep_raddr_p];
    dep_rdata_q_r <= dep_mem[dep_raddr_q];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lca_tbl_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      highest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      highest_r   <= highest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers of the depth walk and the query climb.
  always_ff @(posedge clk) begin
    node_i_r       <= node_i_nxt;
    walk_p_r       <= walk_p_nxt;
    cnt_r          <= cnt_nxt;
    p_r            <= p_nxt;
    q_r            <= q_nxt;
    steps_r        <= steps_nxt;
    climb_p_r      <= climb_p_nxt;
    out_found_r    <= out_found_nxt;
    out_ancestor_r <= out_ancestor_nxt;
  end

  // Sequencer: next state, memory ports and result.
  always_comb begin
    state_nxt        = state_r;
    clr_addr_nxt     = clr_addr_r;
    highest_nxt      = highest_r;
    node_i_nxt       = node_i_r;
    walk_p_nxt       = walk_p_r;
    cnt_nxt          = cnt_r;
    p_nxt            = p_r;
    q_nxt            = q_r;
    steps_nxt        = steps_r;
    climb_p_nxt      = climb_p_r;
    out_valid_nxt    = out_valid_r && !out_chan.ready;
    out_found_nxt    = out_found_r;
    out_ancestor_nxt = out_ancestor_r;
    par_we           = 1'b0;
    par_waddr        = clr_addr_r;
    par_wdata        = '0;
    par_raddr        = walk_p_r;
    dep_we           = 1'b0;
    dep_waddr        = clr_addr_r;
    dep_wdata        = '0;

    case (state_r)
      lca_tbl_pkg::ST_CLEAR: begin
        // Zero both tables one entry per cycle.
        par_we = 1'b1;
        dep_we = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ID_W'(MAX_NODES)) begin
          state_nxt = lca_tbl_pkg::ST_IDLE;
        end
      end

      lca_tbl_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_chan.mode)
            lca_tbl_pkg::MODE_SET_PARENT: begin
              if (in_chan.node_b != '0 && a_ok && b_ok) begin
                par_we    = 1'b1;
                par_waddr = b_id;
                par_wdata = a_id;
                if (a_id > highest_nxt) begin
                  highest_nxt = a_id;
                end
                if (b_id > highest_nxt) begin
                  highest_nxt = b_id;
                end
              end
            end
            lca_tbl_pkg::MODE_DEPTHS: begin
              // Start with node 1; nothing to do if no node was ever named.
              if (highest_r != '0) begin
                node_i_nxt = ID_W'(1);
                walk_p_nxt = ID_W'(1);
                cnt_nxt    = DEP_W'(1);
                par_raddr  = ID_W'(1);
                state_nxt  = lca_tbl_pkg::ST_WALK;
              end
            end
            lca_tbl_pkg::MODE_QUERY: begin
              // An out-of-range node enters as 0, which ends as not found.
              p_nxt     = a_ok ? a_id : '0;
              q_nxt     = b_ok ? b_id : '0;
              steps_nxt = '0;
              state_nxt = lca_tbl_pkg::ST_QRY;
            end
            default: begin
            end
          endcase
        end
      end

      lca_tbl_pkg::ST_WALK: begin
        // par_rdata_r holds the parent of walk_p_r.
        if (walk_more) begin
          walk_p_nxt = par_rdata_r;
          cnt_nxt    = cnt_r + 1'b1;
          par_raddr  = par_rdata_r;
        end else begin
          dep_we    = 1'b1;
          dep_waddr = node_i_r;
          dep_wdata = cnt_r;
          if (node_i_r == highest_r) begin
            state_nxt = lca_tbl_pkg::ST_IDLE;
          end else begin
            node_i_nxt = node_i_r + 1'b1;
            walk_p_nxt = node_i_r + 1'b1;
            cnt_nxt    = DEP_W'(1);
            par_raddr  = node_i_r + 1'b1;
          end
        end
      end

      lca_tbl_pkg::ST_QRY: begin
        // Depth data of p_r and q_r is valid here.
        par_raddr = q_r;
        if (p_r == '0 || q_r == '0 || p_r == q_r ||
            steps_r >= STEP_W'(2 * MAX_NODES)) begin
          if (out_free) begin
            out_valid_nxt    = 1'b1;
            out_found_nxt    = (p_r != '0) && (p_r == q_r);
            out_ancestor_nxt = ((p_r != '0) && (p_r == q_r)) ? NODE_W'(p_r) : '0;
            state_nxt        = lca_tbl_pkg::ST_IDLE;
          end
        end else begin
          climb_p_nxt = (dep_rdata_p_r > dep_rdata_q_r);
          par_raddr   = (dep_rdata_p_r > dep_rdata_q_r) ? p_r : q_r;
          steps_nxt   = steps_r + 1'b1;
          state_nxt   = lca_tbl_pkg::ST_CLIMB;
        end
      end

      lca_tbl_pkg::ST_CLIMB: begin
        // Replace the deeper node (q_r on a tie) with its parent.
        if (climb_p_r) begin
          p_nxt = par_rdata_r;
        end else begin
          q_nxt = par_rdata_r;
        end
        state_nxt = lca_tbl_pkg::ST_QRY;
      end

      default: begin
        state_nxt = lca_tbl_pkg::ST_IDLE;
      end
    endcase
  end

  // The depth reads always follow the pair as it will stand next cycle.
  assign dep_raddr_p = p_nxt;
  assign dep_raddr_q = q_nxt;

  // Checks on the sequencer.
  `LCA_TBL_ASSERT_NOW(a_miss_zero, out_valid_r && !out_found_r, out_ancestor_r == '0, "miss with nonzero ancestor")
  `LCA_TBL_ASSERT_NOW(a_hit_nonzero, out_valid_r && out_found_r, out_ancestor_r != '0, "hit on node zero")
  `LCA_TBL_ASSERT_NOW(a_walk_range, state_r == lca_tbl_pkg::ST_WALK, node_i_r != '0 && node_i_r <= highest_r && cnt_r <= DEP_W'(MAX_NODES), "depth walk out of range")
  `LCA_TBL_ASSERT_NEXT(a_climb_back, state_r == lca_tbl_pkg::ST_CLIMB, state_r == lca_tbl_pkg::ST_QRY, "climb step did not return to compare")

endmodule

### tb/sv/lowest_common_ancestor_table_checker.sv
// Passive checker: keeps its own copy of the parent and depth tables,
// predicts every query answer and compares the answers that come back.
module lowest_common_ancestor_table_checker #(
  parameter int MAX_NODES = lca_tbl_pkg::MAX_NODES_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  lca_tbl_in_if  in_mon,
  lca_tbl_out_if out_mon,
  output int     fail_count,
  output int     pending,
  output int     answers_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                           found;
    logic [lca_tbl_pkg::NODE_W-1:0] ancestor;
  } lca_answer_t;

  // Shadow state of the block.
  int parent_tbl [0:MAX_NODES];
  int depth_tbl  [0:MAX_NODES];
  int top_id;

  // Answers owed by the block, oldest first.
  lca_answer_t answers_due [$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    answers_checked = 0;
  end

  function automatic void wipe_tables();
    for (int n = 0; n <= MAX_NODES; n++) begin
      parent_tbl[n] = 0;
      depth_tbl[n]  = 0;
    end
    top_id = 0;
  endfunction

  // A parent write; out-of-range ids and a zero child are dropped.
  function automatic void apply_link(input int a, input int b);
    if (b == 0 || b > MAX_NODES || a > MAX_NODES) return;
    parent_tbl[b] = a;
    if (a > top_id) top_id = a;
    if (b > top_id) top_id = b;
  endfunction

  // Depth pass over nodes 1..top_id; a depth saturates at MAX_NODES.
  function automatic void relevel();
    int hops;
    int cur;
    for (int n = 0; n <= MAX_NODES; n++) depth_tbl[n] = 0;
    for (int n = 1; n <= top_id && n <= MAX_NODES; n++) begin
      hops = 1;
      cur  = n;
      while (parent_tbl[cur] != 0 && hops < MAX_NODES) begin
        cur = parent_tbl[cur];
        hops++;
      end
      depth_tbl[n] = hops;
    end
  endfunction

  // Climb the deeper node (the second one on a tie) until the two meet.
  function automatic lca_answer_t lca_lookup(input int a, input int b);
    lca_answer_t ans;
    int p;
    int q;
    int steps;
    ans   = '0;
    p     = a;
    q     = b;
    steps = 0;
    if (p == 0 || q == 0 || p > MAX_NODES || q > MAX_NODES) return ans;
    while (p != 0 && q != 0 && p != q) begin
      if (steps >= 2 * MAX_NODES) return ans;
      if (depth_tbl[p] > depth_tbl[q]) p = parent_tbl[p];
      else q = parent_tbl[q];
      steps++;
    end
    if (p == 0 || q == 0) return ans;
    ans.found    = 1'b1;
    ans.ancestor = p[lca_tbl_pkg::NODE_W-1:0];
    return ans;
  endfunction

  task automatic note_fail(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Answers are checked before the new word is applied, so a stray answer
  // can never be matched against a query accepted at the same edge.
  always @(posedge clk) begin : watch
    lca_answer_t due;
    lca_answer_t got;
    if (!rst_n) begin
      wipe_tables();
      answers_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.found    = out_mon.found;
        got.ancestor = out_mon.ancestor;
        if (answers_due.size() == 0) begin
          note_fail($sformatf("unexpected answer found=%0b ancestor=%0d",
                              got.found, got.ancestor));
        end else begin
          due = answers_due.pop_front();
          if (got.found !== due.found || got.ancestor !== due.ancestor)
            note_fail($sformatf(
              "answer %0d: expected found=%0b ancestor=%0d, got found=%0b ancestor=%0d",
              answers_checked, due.found, due.ancestor, got.found, got.ancestor));
          answers_checked++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.mode)
          lca_tbl_pkg::MODE_SET_PARENT:
            apply_link(int'(in_mon.node_a), int'(in_mon.node_b));
          lca_tbl_pkg::MODE_DEPTHS:
            relevel();
          lca_tbl_pkg::MODE_QUERY:
            answers_due.push_back(lca_lookup(int'(in_mon.node_a), int'(in_mon.node_b)));
          default: ;
        endcase
      end
    end
    pending = answers_due.size();
  end

endmodule

### tb/sv/lowest_common_ancestor_table_tb.sv
module lowest_common_ancestor_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXN       = lca_tbl_pkg::MAX_NODES_DEF;
  localparam int MODE_BITS  = lca_tbl_pkg::MODE_W;
  localparam int NODE_BITS  = lca_tbl_pkg::NODE_W;
  localparam int ITEMS      = 400;
  localparam int IDLE_LIMIT = 200000;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  lca_tbl_in_if  in_ch ();
  lca_tbl_out_if out_ch ();

  int chk_fail;
  int chk_pending;
  int chk_answers;

  // Word counts by kind, and the random gap switches.
  int links;
  int passes;
  int queries;
  int dropped;
  bit in_calm;
  bit out_calm;
  int idle_cycles;

  lowest_common_ancestor_table #(.MAX_NODES(MAXN)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_ch),
    .out_chan(out_ch)
  );

  lowest_common_ancestor_table_checker #(.MAX_NODES(MAXN)) chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .fail_count     (chk_fail),
    .pending        (chk_pending),
    .answers_checked(chk_answers)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one; none while calm.
  function automatic int pick_gap(input bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one command word at the falling edge and hold it until taken.
  task automatic send_word(input logic [MODE_BITS-1:0] m, input int a, input int b);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= m;
    in_ch.node_a <= NODE_BITS'(a);
    in_ch.node_b <= NODE_BITS'(b);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (m)
      lca_tbl_pkg::MODE_SET_PARENT: begin
        if (b != 0 && b <= MAXN && a <= MAXN) links++;
        else dropped++;
      end
      lca_tbl_pkg::MODE_DEPTHS: passes++;
      lca_tbl_pkg::MODE_QUERY:  queries++;
      default:                  dropped++;
    endcase
    @(negedge clk);
  endtask

  task automatic random_node_pair(input int base, input int span);
    int a;
    int b;
    a = base + $urandom_range(0, span - 1);
    b = base + $urandom_range(0, span - 1);
    if ($urandom_range(0, 9) == 0) a = $urandom_range(0, 511);
    if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 511);
    send_word(lca_tbl_pkg::MODE_QUERY, a, b);
  endtask

  // One random episode: grow a forest in a window of ids, maybe add noise,
  // usually recompute depths, then query pairs mostly inside the window.
  task automatic random_episode();
    int span;
    int base;
    int roll;
    bit chain;
    chain = ($urandom_range(0, 7) == 0);
    span  = chain ? $urandom_range(24, 40) : $urandom_range(6, 16);
    base  = $urandom_range(1, MAXN + 1 - span);
    in_calm  = ($urandom_range(0, 4) == 0);
    out_calm = ($urandom_range(0, 4) == 0);
    for (int k = 1; k < span; k++) begin
      roll = $urandom_range(0, 9);
      if (chain) send_word(lca_tbl_pkg::MODE_SET_PARENT, base + k - 1, base + k);
      else if (roll < 7)
        send_word(lca_tbl_pkg::MODE_SET_PARENT, base + $urandom_range(0, k - 1), base + k);
      else if (roll < 9) send_word(lca_tbl_pkg::MODE_SET_PARENT, 0, base + k);
    end
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 3))
        send_word(MODE_BITS'($urandom_range(0, 3)), $urandom_range(0, 511),
                  $urandom_range(0, 511));
    end
    if ($urandom_range(0, 99) < 85)
      send_word(lca_tbl_pkg::MODE_DEPTHS, $urandom_range(0, 511), $urandom_range(0, 511));
    repeat ($urandom_range(4, 10)) random_node_pair(base, span);
  endtask

  // Result-side back-pressure.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = pick_gap(out_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Cycles without any accepted word on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("lowest_common_ancestor_table_tb failed");
    $finish;
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = lca_tbl_pkg::MODE_SET_PARENT;
    in_ch.node_a = '0;
    in_ch.node_b = '0;
    idle_cycles  = 0;
    links        = 0;
    passes       = 0;
    queries      = 0;
    dropped      = 0;
    in_calm      = 1'b0;
    out_calm     = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Queries with node zero or an out-of-range node, and a node queried against itself.
    send_word(lca_tbl_pkg::MODE_QUERY, 0, 0);
    send_word(lca_tbl_pkg::MODE_QUERY, 511, 256);
    send_word(lca_tbl_pkg::MODE_QUERY, 5, 5);
    // Writes that must be dropped, and the unused mode.
    send_word(lca_tbl_pkg::MODE_SET_PARENT, 3, 0);
    send_word(lca_tbl_pkg::MODE_SET_PARENT, 257, 4);
    send_word(lca_tbl_pkg::MODE_SET_PARENT, 2, 511);
    send_word(MODE_UNUSED, 511, 511);
    // A small tree, depths, then a node outside the depth pass.
    send_word(lca_tbl_pkg::MODE_SET_PARENT, 1, 2);
    send_word(lca_tbl_pkg::MODE_SET_PARENT, 2, 4);
    send_word(lca_tbl_pkg::MODE_SET_PARENT, 2, 5);
    send_word(lca_tbl_pkg::MODE_SET_PARENT, 1, 3);
    send_word(lca_tbl_pkg::MODE_DEPTHS, 0, 0);
    send_word(lca_tbl_pkg::MODE_QUERY, 4, 5);
    send_word(lca_tbl_pkg::MODE_QUERY, 4, 200);
    // The highest id, queried first with stale depths.
    send_word(lca_tbl_pkg::MODE_SET_PARENT, 256, 8);
    send_word(lca_tbl_pkg::MODE_QUERY, 8, 4);
    send_word(lca_tbl_pkg::MODE_DEPTHS, 0, 0);
    send_word(lca_tbl_pkg::MODE_QUERY, 8, 256);
    // Two separate loops: depths saturate and a cross query hits the step cap.
    send_word(lca_tbl_pkg::MODE_SET_PARENT, 11, 10);
    send_word(lca_tbl_pkg::MODE_SET_PARENT, 10, 11);
    send_word(lca_tbl_pkg::MODE_SET_PARENT, 21, 20);
    send_word(lca_tbl_pkg::MODE_SET_PARENT, 20, 21);
    send_word(lca_tbl_pkg::MODE_DEPTHS, 0, 0);
    send_word(lca_tbl_pkg::MODE_QUERY, 10, 20);
    send_word(lca_tbl_pkg::MODE_QUERY, 11, 10);
    // Parent id zero breaks both loops again.
    send_word(lca_tbl_pkg::MODE_SET_PARENT, 0, 10);
    send_word(lca_tbl_pkg::MODE_SET_PARENT, 0, 20);

    while (links + passes + queries < ITEMS) random_episode();
    in_ch.valid <= 1'b0;
    out_calm = 1'b0;

    // Drain, then give a trailing depth pass or query time to misbehave.
    wait (chk_pending == 0);
    repeat (4 * MAXN + 8) @(posedge clk);

    $display("Covered %0d parent writes, %0d depth passes, %0d queries, %0d dropped words.",
             links, passes, queries, dropped);
    $display("Checked %0d answers; %0d failures.", chk_answers, chk_fail);
    if (chk_fail == 0) begin
      $display("lowest_common_ancestor_table_tb passed");
    end else begin
      $display("lowest_common_ancestor_table_tb failed");
    end
    $finish;
  end

endmodule
